[hw/rtl/sha256_compression_core_defines.svh]
// Assertion macros shared by the compression core
`ifndef SHA256_COMPRESSION_CORE_DEFINES_SVH
`define SHA256_COMPRESSION_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define SHAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define SHAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sha256c_pkg.sv]
package sha256c_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned NumRound = 64;
  localparam int unsigned RoundW   = $clog2(NumRound);

  typedef struct packed {
    logic [WordW-1:0] msg_word;
    logic             start_message;
    logic             end_message;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic             digest_last;
  } out_item_t;

  typedef enum logic [3:0] {
    StLoad   = 4'b0001,
    StRound  = 4'b0010,
    StUpdate = 4'b0100,
    StEmit   = 4'b1000
  } ctrl_state_e;

  typedef struct packed {
    logic              load_word;
    logic              reload_iv;
    logic              iv_sel;
    logic              init_vars;
    logic              round_en;
    logic [RoundW-1:0] round_idx;
    logic              update_hash;
    logic [2:0]        emit_idx;
  } dp_cmd_t;

  localparam logic [WordW-1:0] Iv256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] Iv224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  localparam logic [2:0] LastIdx256 = 3'd7;
  localparam logic [2:0] LastIdx224 = 3'd6;

  localparam logic [WordW-1:0] RoundK [NumRound] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[hw/rtl/sha256c_dp.sv]
module sha256c_dp import sha256c_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  logic [WordW-1:0] msg_word_i,
  output logic [WordW-1:0] digest_word_o
);

  logic [WordW-1:0] hash_q [8];
  logic [WordW-1:0] win_q  [16];
  logic [WordW-1:0] var_q  [8];

  logic [WordW-1:0] w_next;
  logic [WordW-1:0] ch_val;
  logic [WordW-1:0] maj_val;
  logic [WordW-1:0] t1_val;
  logic [WordW-1:0] t2_val;

  always_comb begin
    w_next  = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];
    ch_val  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
    maj_val = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
    t1_val  = var_q[7] + big_sigma1(var_q[4]) + ch_val + RoundK[cmd_i.round_idx] + win_q[0];
    t2_val  = big_sigma0(var_q[0]) + maj_val;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word || cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= cmd_i.load_word ? msg_word_i : w_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_vars) begin
      for (int i = 0; i < 8; i++) begin
        var_q[i] <= hash_q[i];
      end
    end else if (cmd_i.round_en) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1_val;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1_val + t2_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= Iv256[i];
      end
    end else if (cmd_i.reload_iv) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= cmd_i.iv_sel ? Iv224[i] : Iv256[i];
      end
    end else if (cmd_i.update_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_q[i] + var_q[i];
      end
    end
  end

  assign digest_word_o = hash_q[cmd_i.emit_idx];

endmodule

[hw/rtl/sha256c_ctrl.sv]
`include "sha256_compression_core_defines.svh"

module sha256c_ctrl import sha256c_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  logic    start_i,
  input  logic    end_i,
  input  logic    cfg_valid_i,
  output logic    cfg_ready_o,
  input  logic    cfg_mode_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output logic    out_last_o,
  output dp_cmd_t cmd_o
);

  ctrl_state_e       state_q, state_d;
  logic [3:0]        word_cnt_q, word_cnt_d;
  logic [RoundW-1:0] round_q, round_d;
  logic [2:0]        emit_q, emit_d;
  logic [2:0]        last_idx_q, last_idx_d;
  logic              end_pend_q, end_pend_d;
  logic              mode_q;

  logic in_acc;
  logic out_acc;
  logic last_word;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StLoad);
  assign out_valid_o = (state_q == StEmit);
  assign out_last_o  = (emit_q == last_idx_q);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign last_word   = (word_cnt_q == 4'd15);

  always_comb begin
    state_d    = state_q;
    word_cnt_d = word_cnt_q;
    round_d    = round_q;
    emit_d     = emit_q;
    last_idx_d = last_idx_q;
    end_pend_d = end_pend_q;

    cmd_o             = '0;
    cmd_o.iv_sel      = mode_q;
    cmd_o.round_idx   = round_q;
    cmd_o.emit_idx    = emit_q;

    unique case (state_q)
      StLoad: begin
        if (in_acc) begin
          cmd_o.load_word = 1'b1;
          cmd_o.reload_iv = start_i && (word_cnt_q == '0);
          cmd_o.init_vars = last_word;
          word_cnt_d      = word_cnt_q + 4'd1;
          end_pend_d      = end_pend_q | end_i;
          if (last_word) begin
            round_d = '0;
            state_d = StRound;
          end
        end
      end
      StRound: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + RoundW'(1);
        if (round_q == RoundW'(NumRound - 1)) begin
          state_d = StUpdate;
        end
      end
      StUpdate: begin
        cmd_o.update_hash = 1'b1;
        if (end_pend_q) begin
          end_pend_d = 1'b0;
          emit_d     = '0;
          last_idx_d = mode_q ? LastIdx224 : LastIdx256;
          state_d    = StEmit;
        end else begin
          state_d = StLoad;
        end
      end
      StEmit: begin
        if (out_acc) begin
          emit_d = emit_q + 3'd1;
          if (out_last_o) begin
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StLoad;
      word_cnt_q <= '0;
      round_q    <= '0;
      emit_q     <= '0;
      last_idx_q <= LastIdx256;
      end_pend_q <= 1'b0;
      mode_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      word_cnt_q <= word_cnt_d;
      round_q    <= round_d;
      emit_q     <= emit_d;
      last_idx_q <= last_idx_d;
      end_pend_q <= end_pend_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= cfg_mode_i;
      end
    end
  end

  `SHAC_ASSERT_SAME(a_no_input_while_emit, out_valid_o, in_stall_o, "input taken during digest output")
  `SHAC_ASSERT_NEXT(a_block_starts_rounds, in_acc && last_word, (state_q == StRound) && (round_q == '0), "rounds did not start after block")
  `SHAC_ASSERT_NEXT(a_rounds_end_update, (state_q == StRound) && (round_q == RoundW'(NumRound - 1)), state_q == StUpdate, "hash update missed after last round")
  `SHAC_ASSERT_NEXT(a_last_word_returns, out_acc && out_last_o, (state_q == StLoad) && (word_cnt_q == '0), "core did not return to word loading")

endmodule

[hw/rtl/sha256_compression_core.sv]
// Channel  | Direction | Handshake              | Payload
// input    | in        | in_valid_i / in_stall_o | in_data_i  (msg_word, start/end flags)
// output   | out       | out_valid_o / out_stall_i | out_data_o (digest_word, digest_last)
// config   | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (mode)
//
// Words of a block are taken one per cycle; after the sixteenth the core runs
// the 64 rounds and then one hash update.
// One shared round unit does one round per cycle.
// A final block adds 7 (SHA-224) or 8 (SHA-256) output words, one per transaction.
// Reset loads the SHA-256 initial values and clears mode; input stalls from the
// sixteenth word until rounds, the hash update and any digest output are done.
module sha256_compression_core import sha256c_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  dp_cmd_t          cmd;
  logic [WordW-1:0] digest_word;
  logic             digest_last;

  sha256c_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .start_i     (in_data_i.start_message),
    .end_i       (in_data_i.end_message),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_mode_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_last_o  (digest_last),
    .cmd_o       (cmd)
  );

  sha256c_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_word_i    (in_data_i.msg_word),
    .digest_word_o (digest_word)
  );

  assign out_data_o.digest_word = digest_word;
  assign out_data_o.digest_last = digest_last;

endmodule

[dv/sha256_compression_core_tb.sv]
`timescale 1ns / 1ps

module sha256_compression_core_tb;
  import sha256c_pkg::in_item_t;
  import sha256c_pkg::out_item_t;

  localparam int SettleCycles = 100;
  localparam int WatchdogLimit = 2000;
  localparam int WordsPerPhase = 52;

  localparam logic [31:0] KConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH256 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] InitH224 [8] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;

  sha256_compression_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  in_item_t  word_q [$];
  out_item_t digest_q [$];

  logic [31:0] chain [8];
  logic [31:0] blk_words [16];
  logic [3:0]  word_idx = '0;
  logic        end_seen = 1'b0;
  logic        sha224_sel = 1'b0;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int errors = 0;
  int words_in = 0;
  int blocks_done = 0;
  int digests_done = 0;
  int digest_words_checked = 0;
  int mode_writes = 0;
  int idle_cycles = 0;

  int gen_pos = 0;
  int gen_blocks_left = 0;
  int gen_end_pos = 15;
  logic gen_fresh = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < 8; i++) chain[i] = InitH256[i];
  end

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = blk_words[t];
    for (int t = 16; t < 64; t++) begin
      s0 = rotr32(w[t-15], 7) ^ rotr32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr32(w[t-2], 17) ^ rotr32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    va = chain[0]; vb = chain[1]; vc = chain[2]; vd = chain[3];
    ve = chain[4]; vf = chain[5]; vg = chain[6]; vh = chain[7];
    for (int t = 0; t < 64; t++) begin
      s1 = rotr32(ve, 6) ^ rotr32(ve, 11) ^ rotr32(ve, 25);
      t1 = vh + s1 + ((ve & vf) ^ (~ve & vg)) + KConst[t] + w[t];
      s0 = rotr32(va, 2) ^ rotr32(va, 13) ^ rotr32(va, 22);
      t2 = s0 + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + t1;
      vd = vc; vc = vb; vb = va; va = t1 + t2;
    end
    chain[0] += va; chain[1] += vb; chain[2] += vc; chain[3] += vd;
    chain[4] += ve; chain[5] += vf; chain[6] += vg; chain[7] += vh;
  endfunction

  task automatic absorb_word(input in_item_t it);
    out_item_t d;
    int n;
    if (it.start_message && word_idx == 4'd0) begin
      for (int i = 0; i < 8; i++) chain[i] = sha224_sel ? InitH224[i] : InitH256[i];
    end
    if (it.end_message) end_seen = 1'b1;
    blk_words[word_idx] = it.msg_word;
    if (word_idx != 4'd15) begin
      word_idx = word_idx + 4'd1;
    end else begin
      word_idx = 4'd0;
      compress_block();
      blocks_done++;
      if (end_seen) begin
        end_seen = 1'b0;
        n = sha224_sel ? 7 : 8;
        for (int k = 0; k < n; k++) begin
          d.digest_word = chain[k];
          d.digest_last = (k == n - 1);
          digest_q.push_back(d);
        end
        digests_done++;
      end
    end
  endtask

  task automatic push_word(input logic [31:0] w, input logic s, input logic e);
    in_item_t it;
    it.msg_word = w;
    it.start_message = s;
    it.end_message = e;
    word_q.push_back(it);
  endtask

  // Mostly well-formed messages of one to three blocks, with stray flags mixed in.
  task automatic gen_words(input int n);
    logic [31:0] w;
    logic s, e;
    int sel;
    repeat (n) begin
      if (gen_pos == 0 && gen_blocks_left == 0) begin
        gen_blocks_left = $urandom_range(3, 1);
        gen_fresh = ($urandom_range(9) != 0);
      end
      if (gen_pos == 0 && gen_blocks_left == 1)
        gen_end_pos = ($urandom_range(7) == 0) ? $urandom_range(15) : 15;
      sel = $urandom_range(7);
      w = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hffffffff : $urandom;
      s = (gen_pos == 0) ? gen_fresh : ($urandom_range(11) == 0);
      e = (gen_blocks_left == 1 && gen_pos == gen_end_pos) || ($urandom_range(39) == 0);
      push_word(w, s, e);
      gen_fresh = 1'b0;
      if (gen_pos == 15) begin
        gen_pos = 0;
        gen_blocks_left--;
      end else begin
        gen_pos++;
      end
    end
  endtask

  task automatic write_mode(input logic val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sha224_sel = val;
    mode_writes++;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (word_q.size() != 0 || in_valid_i || digest_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        absorb_word(in_data_i);
        words_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (word_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i <= word_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        digest_words_checked++;
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest transaction word=%h last=%b", $time,
                   out_data_o.digest_word, out_data_o.digest_last);
          errors++;
        end else begin
          want = digest_q.pop_front();
          if (out_data_o.digest_word !== want.digest_word) begin
            $display("%0t: digest_word mismatch expected=%h actual=%h", $time,
                     want.digest_word, out_data_o.digest_word);
            errors++;
          end
          if (out_data_o.digest_last !== want.digest_last) begin
            $display("%0t: digest_last mismatch expected=%b actual=%b", $time,
                     want.digest_last, out_data_o.digest_last);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
      $display("sha256_compression_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // End flag early in the block, start flag mid-block, extreme word values.
    push_word(32'h00000000, 1'b1, 1'b0);
    push_word(32'hffffffff, 1'b0, 1'b0);
    push_word(32'h80000000, 1'b0, 1'b1);
    push_word(32'h00000001, 1'b0, 1'b0);
    push_word(32'h7fffffff, 1'b0, 1'b0);
    push_word(32'hfffffffe, 1'b1, 1'b0);
    push_word(32'ha5a5a5a5, 1'b0, 1'b0);
    push_word(32'h5a5a5a5a, 1'b0, 1'b0);
    push_word(32'hffffffff, 1'b0, 1'b0);
    push_word(32'h00000000, 1'b0, 1'b0);
    push_word(32'h61626380, 1'b0, 1'b0);
    push_word(32'h00000018, 1'b0, 1'b0);
    push_word(32'hdeadbeef, 1'b0, 1'b0);
    push_word(32'h0f0f0f0f, 1'b0, 1'b0);
    push_word(32'hf0f0f0f0, 1'b0, 1'b0);
    push_word(32'hffffffff, 1'b0, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p >> 1)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 58; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 58; end
        default: begin src_idle_pct = 17; snk_stall_pct = 17; end
      endcase
      write_mode(~p[0]);
      gen_words(WordsPerPhase);
      drain();
    end

    $display("Covered %0d message words in %0d blocks and %0d digests (%0d words checked),",
             words_in, blocks_done, digests_done, digest_words_checked);
    $display("with %0d mode writes across four handshake pacing profiles.", mode_writes);
    if (errors == 0) begin
      $display("sha256_compression_core verification clean");
    end else begin
      $display("sha256_compression_core verification failed");
    end
    $finish;
  end

endmodule

[sha256_compression_core.f]
+incdir+hw/rtl
hw/rtl/sha256c_pkg.sv
hw/rtl/sha256c_dp.sv
hw/rtl/sha256c_ctrl.sv
hw/rtl/sha256_compression_core.sv
dv/sha256_compression_core_tb.sv
